>>> rtl/alle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and codes for the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT   = 3'd0,
		MODE_PUSH_BACK    = 3'd1,
		MODE_INS_BEFORE   = 3'd2,
		MODE_INS_AFTER    = 3'd3,
		MODE_DELETE       = 3'd4,
		MODE_FIND_VALUE   = 3'd5,
		MODE_FIND_POS     = 3'd6,
		MODE_CLEAR        = 3'd7
	} mode_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// micro-operations issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_RES_FULL,
		CMD_WALK_START,
		CMD_WALK_STEP,
		CMD_RES_NF,
		CMD_RES_FOUND,
		CMD_DEL_SAVE,
		CMD_INS_SAVE,
		CMD_FETCH,
		CMD_LINK1,
		CMD_LINK2,
		CMD_DEL1,
		CMD_DEL2,
		CMD_SWEEP,
		CMD_SWEEP_END
	} cmd_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_WSTART,
		S_WALK,
		S_FETCH,
		S_LINK1,
		S_LINK2,
		S_DEL1,
		S_DEL2,
		S_CLEAR
	} state_t;

	typedef struct packed {
		logic free_zero;
		logic head_zero;
		logic hit;
		logic walk_end;
		logic sweep_last;
	} dp_status_t;

endpackage

>>> rtl/alle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/alle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ctrl
// Sequencer: walks each operation through its micro-operation steps.
// ----------------------------------------------------------------------------
module alle_ctrl import alle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] mode,
	input  dp_status_t st,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;
	mode_t  mode_q;
	logic   done_q, res;
	mode_t  mode_in;

	assign mode_in = mode_t'(mode);
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			mode_q  <= MODE_PUSH_FRONT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res;
			if (state_q == S_IDLE && start) begin
				mode_q <= mode_in;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					unique case (mode_in)
						MODE_PUSH_FRONT, MODE_PUSH_BACK:
							state_d = st.free_zero ? S_IDLE : S_FETCH;
						MODE_INS_BEFORE, MODE_INS_AFTER:
							state_d = st.free_zero ? S_IDLE : S_WSTART;
						MODE_DELETE, MODE_FIND_VALUE, MODE_FIND_POS:
							state_d = S_WSTART;
						MODE_CLEAR:
							state_d = S_CLEAR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WSTART: state_d = st.head_zero ? S_IDLE : S_WALK;
			S_WALK: begin
				if (st.hit) begin
					unique case (mode_q)
						MODE_DELETE:                    state_d = S_DEL1;
						MODE_INS_BEFORE, MODE_INS_AFTER: state_d = S_FETCH;
						default:                        state_d = S_IDLE;
					endcase
				end else if (st.walk_end) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: state_d = S_LINK1;
			S_LINK1: state_d = S_LINK2;
			S_LINK2: state_d = S_IDLE;
			S_DEL1:  state_d = S_DEL2;
			S_DEL2:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = CMD_NONE;
		res = 1'b0;
		unique case (state_q)
			S_INIT: cmd = st.sweep_last ? CMD_SWEEP_END : CMD_SWEEP;
			S_CLEAR: begin
				cmd = st.sweep_last ? CMD_SWEEP_END : CMD_SWEEP;
				res = st.sweep_last;
			end
			S_IDLE: begin
				if (start) begin
					if (st.free_zero && (mode_in == MODE_PUSH_FRONT ||
						mode_in == MODE_PUSH_BACK || mode_in == MODE_INS_BEFORE ||
						mode_in == MODE_INS_AFTER)) begin
						cmd = CMD_RES_FULL;
						res = 1'b1;
					end else begin
						cmd = CMD_ACCEPT;
					end
				end
			end
			S_WSTART: begin
				cmd = st.head_zero ? CMD_RES_NF : CMD_WALK_START;
				res = st.head_zero;
			end
			S_WALK: begin
				if (st.hit) begin
					unique case (mode_q)
						MODE_DELETE:                    cmd = CMD_DEL_SAVE;
						MODE_INS_BEFORE, MODE_INS_AFTER: cmd = CMD_INS_SAVE;
						default: begin
							cmd = CMD_RES_FOUND;
							res = 1'b1;
						end
					endcase
				end else if (st.walk_end) begin
					cmd = CMD_RES_NF;
					res = 1'b1;
				end else begin
					cmd = CMD_WALK_STEP;
				end
			end
			S_FETCH: cmd = CMD_FETCH;
			S_LINK1: cmd = CMD_LINK1;
			S_LINK2: begin
				cmd = CMD_LINK2;
				res = 1'b1;
			end
			S_DEL1: cmd = CMD_DEL1;
			S_DEL2: begin
				cmd = CMD_DEL2;
				res = 1'b1;
			end
			default: cmd = CMD_NONE;
		endcase
	end

endmodule

>>> rtl/alle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_dp
// Datapath: item and link tables, list pointers, walk cursor, result regs.
// ----------------------------------------------------------------------------
module alle_dp import alle_pkg::*; #(
	parameter int SLOTS     = 32,
	parameter int ITEM_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [2:0]           mode,
	input  logic [ITEM_BITS-1:0] item,
	input  logic [ITEM_BITS-1:0] anchor,
	input  logic [4:0]           position,
	output dp_status_t           st,
	output logic [1:0]           status,
	output logic [4:0]           slot,
	output logic [ITEM_BITS-1:0] item_out,
	output logic [4:0]           count
);

	localparam int SW = $clog2(SLOTS);
	localparam int NW = (SW > 5) ? SW : 5;
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	// list state
	logic [SW-1:0] head_q, tail_q, free_q, count_q, i_q;
	// operation registers
	mode_t                mode_q;
	logic [ITEM_BITS-1:0] item_q, anchor_q, hold_q;
	logic [4:0]           pos_q;
	logic [SW-1:0]        cur_q, new_q, p_q, s_q, n_q;
	logic [1:0]           status_q;
	logic [SW-1:0]        slot_q;
	logic [ITEM_BITS-1:0] res_item_q;

	// table ports
	logic [SW-1:0]        raddr;
	logic [ITEM_BITS-1:0] item_rd;
	logic [SW-1:0]        next_rd, prev_rd;
	logic                 iwe, nwe, pwe;
	logic [SW-1:0]        iaddr, naddr, paddr, ndata, pdata;
	logic [SW-1:0]        lnk_p, lnk_n;
	logic [ITEM_BITS-1:0] key;

	alle_ram #(.WIDTH(ITEM_BITS), .DEPTH(SLOTS)) u_item_ram (
		.clk(clk), .we(iwe), .waddr(iaddr), .wdata(item_q),
		.raddr(raddr), .rdata(item_rd)
	);
	alle_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
		.clk(clk), .we(nwe), .waddr(naddr), .wdata(ndata),
		.raddr(raddr), .rdata(next_rd)
	);
	alle_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
		.clk(clk), .we(pwe), .waddr(paddr), .wdata(pdata),
		.raddr(raddr), .rdata(prev_rd)
	);

	assign key = (mode_q == MODE_INS_BEFORE || mode_q == MODE_INS_AFTER) ? anchor_q : item_q;

	assign st.free_zero  = (free_q == '0);
	assign st.head_zero  = (head_q == '0);
	assign st.walk_end   = (next_rd == '0);
	assign st.sweep_last = (i_q == LAST);
	assign st.hit = (mode_q == MODE_FIND_POS) ? (NW'(n_q) == NW'(pos_q)) : (item_rd == key);

	assign status   = status_q;
	assign slot     = 5'(slot_q);
	assign item_out = res_item_q;
	assign count    = 5'(count_q);

	// shared read address
	always_comb begin
		case (cmd)
			CMD_WALK_START: raddr = head_q;
			CMD_WALK_STEP:  raddr = next_rd;
			CMD_FETCH:      raddr = free_q;
			default:        raddr = cur_q;
		endcase
	end

	// links of the new entry
	always_comb begin
		case (mode_q)
			MODE_PUSH_FRONT: begin lnk_p = '0;     lnk_n = head_q; end
			MODE_PUSH_BACK:  begin lnk_p = tail_q; lnk_n = '0;     end
			MODE_INS_BEFORE: begin lnk_p = s_q;    lnk_n = cur_q;  end
			default:         begin lnk_p = cur_q;  lnk_n = s_q;    end
		endcase
	end

	// table writes
	always_comb begin
		iwe = 1'b0; iaddr = free_q;
		nwe = 1'b0; naddr = cur_q; ndata = '0;
		pwe = 1'b0; paddr = cur_q; pdata = '0;
		case (cmd)
			CMD_SWEEP, CMD_SWEEP_END: begin
				nwe   = 1'b1;
				naddr = i_q;
				ndata = (i_q == '0 || i_q == LAST) ? '0 : SW'(i_q + SW'(1));
				pwe   = 1'b1;
				paddr = i_q;
				pdata = (i_q == '0) ? '0 : SW'(i_q - SW'(1));
			end
			CMD_LINK1: begin
				iwe = 1'b1;
				nwe = 1'b1; naddr = free_q; ndata = lnk_n;
				pwe = 1'b1; paddr = free_q; pdata = lnk_p;
			end
			CMD_LINK2: begin
				case (mode_q)
					MODE_PUSH_FRONT: begin
						pwe = (head_q != '0); paddr = head_q; pdata = new_q;
					end
					MODE_PUSH_BACK: begin
						nwe = (tail_q != '0); naddr = tail_q; ndata = new_q;
					end
					MODE_INS_BEFORE: begin
						pwe = 1'b1; paddr = cur_q; pdata = new_q;
						nwe = (s_q != '0); naddr = s_q; ndata = new_q;
					end
					default: begin
						nwe = 1'b1; naddr = cur_q; ndata = new_q;
						pwe = (s_q != '0); paddr = s_q; pdata = new_q;
					end
				endcase
			end
			CMD_DEL1: begin
				nwe = (p_q != '0); naddr = p_q; ndata = s_q;
				pwe = (s_q != '0); paddr = s_q; pdata = p_q;
			end
			CMD_DEL2: begin
				nwe = 1'b1; naddr = cur_q; ndata = free_q;
			end
			default: ;
		endcase
	end

	// list pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= SW'(1);
			count_q <= '0;
			i_q     <= '0;
		end else begin
			case (cmd)
				CMD_SWEEP: i_q <= SW'(i_q + SW'(1));
				CMD_SWEEP_END: begin
					i_q     <= '0;
					head_q  <= '0;
					tail_q  <= '0;
					free_q  <= SW'(1);
					count_q <= '0;
				end
				CMD_LINK1: begin
					free_q  <= next_rd;
					count_q <= SW'(count_q + SW'(1));
				end
				CMD_LINK2: begin
					case (mode_q)
						MODE_PUSH_FRONT: begin
							if (head_q == '0) tail_q <= new_q;
							head_q <= new_q;
						end
						MODE_PUSH_BACK: begin
							if (tail_q == '0) head_q <= new_q;
							tail_q <= new_q;
						end
						MODE_INS_BEFORE: begin
							if (s_q == '0) head_q <= new_q;
						end
						default: begin
							if (s_q == '0) tail_q <= new_q;
						end
					endcase
				end
				CMD_DEL1: begin
					if (p_q == '0) head_q <= s_q;
					if (s_q == '0) tail_q <= p_q;
					if (count_q != '0) count_q <= SW'(count_q - SW'(1));
				end
				CMD_DEL2: free_q <= cur_q;
				default: ;
			endcase
		end
	end

	// operation and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT, CMD_RES_FULL: begin
				mode_q   <= mode_t'(mode);
				item_q   <= item;
				anchor_q <= anchor;
				pos_q    <= position;
				if (cmd == CMD_RES_FULL) begin
					status_q   <= ST_FULL;
					slot_q     <= '0;
					res_item_q <= '0;
				end
			end
			CMD_WALK_START: begin
				cur_q <= head_q;
				n_q   <= '0;
			end
			CMD_WALK_STEP: begin
				cur_q <= next_rd;
				n_q   <= SW'(n_q + SW'(1));
			end
			CMD_RES_NF: begin
				status_q   <= ST_NOT_FOUND;
				slot_q     <= '0;
				res_item_q <= '0;
			end
			CMD_RES_FOUND: begin
				status_q   <= ST_OK;
				slot_q     <= cur_q;
				res_item_q <= item_rd;
			end
			CMD_DEL_SAVE: begin
				p_q    <= prev_rd;
				s_q    <= next_rd;
				hold_q <= item_rd;
			end
			CMD_INS_SAVE: s_q <= (mode_q == MODE_INS_BEFORE) ? prev_rd : next_rd;
			CMD_LINK1: new_q <= free_q;
			CMD_LINK2: begin
				status_q   <= ST_OK;
				slot_q     <= new_q;
				res_item_q <= '0;
			end
			CMD_DEL2: begin
				status_q   <= ST_OK;
				slot_q     <= cur_q;
				res_item_q <= hold_q;
			end
			CMD_SWEEP_END: begin
				status_q   <= ST_OK;
				slot_q     <= '0;
				res_item_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/array_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit
// Doubly linked list of items kept in slot tables, with a free chain.
// ----------------------------------------------------------------------------
// Issue an operation by raising start while busy is low; one result per
// operation comes back on status/slot/item_out/count, marked by a one-cycle
// done strobe, and must be taken in that cycle (there is no result stall).
// A table-full error is answered straight from idle, without a search.
// Searches advance one linked slot per cycle, bounded by the single read
// port of the slot tables. After reset the link tables are rebuilt in a
// sweep over all slots, during which busy stays high. Slot 0 is the
// sentinel; at most SLOTS-1 entries fit.
// ----------------------------------------------------------------------------
module array_linked_list_engine_unit import alle_pkg::*; #(
	parameter int SLOTS     = 32,
	parameter int ITEM_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           mode,
	input  logic [ITEM_BITS-1:0] item,
	input  logic [ITEM_BITS-1:0] anchor,
	input  logic [4:0]           position,
	output logic                 done,
	output logic [1:0]           status,
	output logic [4:0]           slot,
	output logic [ITEM_BITS-1:0] item_out,
	output logic [4:0]           count
);

	cmd_t       cmd;
	dp_status_t st;

	// sequencer
	alle_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode),
		.st(st), .cmd(cmd), .busy(busy), .done(done)
	);

	// tables, pointers and result registers
	alle_dp #(.SLOTS(SLOTS), .ITEM_BITS(ITEM_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .mode(mode),
		.item(item), .anchor(anchor), .position(position), .st(st),
		.status(status), .slot(slot), .item_out(item_out), .count(count)
	);

endmodule

>>> rtl/alle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_checker
// Port-level checks for the linked list engine.
// ----------------------------------------------------------------------------
module alle_checker import alle_pkg::*; #(
	parameter int ITEM_BITS = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [2:0]           mode,
	input logic [ITEM_BITS-1:0] item,
	input logic [ITEM_BITS-1:0] anchor,
	input logic [4:0]           position,
	input logic                 done,
	input logic [1:0]           status,
	input logic [4:0]           slot,
	input logic [ITEM_BITS-1:0] item_out,
	input logic [4:0]           count
);

	// an accepted transfer is either working or answered at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accept lost");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL || status == ST_NOT_FOUND) |->
		slot == 5'd0 && item_out == '0) else $error("error result not zero");

	// a full table stays full across a full error
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> $stable(count)) else $error("full changed count");

endmodule

bind array_linked_list_engine_unit alle_checker #(.ITEM_BITS(ITEM_BITS)) u_chk (.*);

>>> tb/sv/array_linked_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_unit_tb
// Self-checking bench for the array linked list engine: a behavioral list
// model predicts every result, a monitor compares each done strobe with the
// oldest prediction, and named tests cover directed and random traffic.
// ----------------------------------------------------------------------------
module array_linked_list_engine_unit_tb;
	import alle_pkg::*;

	localparam int NSLOT = 32;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot;
		logic [31:0] item_out;
		logic [4:0]  count;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [31:0] item;
	logic [31:0] anchor;
	logic [4:0]  position;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  slot;
	logic [31:0] item_out;
	logic [4:0]  count;

	array_linked_list_engine_unit #(.SLOTS(NSLOT), .ITEM_BITS(32)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .item(item), .anchor(anchor), .position(position),
		.done(done), .status(status), .slot(slot), .item_out(item_out),
		.count(count)
	);

	// model state of the slot tables
	logic [31:0] m_item [NSLOT];
	logic [4:0]  m_next [NSLOT];
	logic [4:0]  m_prev [NSLOT];
	logic [4:0]  m_head, m_tail, m_free, m_count;

	list_result_t pending_results [$];
	int          n_sent, n_checked, n_errors;
	int          n_full, n_nf, n_del_ok;
	logic [31:0] live_keys [$]; // items believed to be in the list

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// List model
	// ---------------------------------------------------------------
	function automatic void list_rebuild();
		for (int i = 0; i < NSLOT; i++) begin
			m_next[i] = (i == 0 || i + 1 >= NSLOT) ? 5'd0 : 5'(i + 1);
			m_prev[i] = (i == 0) ? 5'd0 : 5'(i - 1);
		end
		m_head  = '0;
		m_tail  = '0;
		m_free  = 5'd1;
		m_count = '0;
	endfunction

	function automatic logic [4:0] list_find(logic [31:0] key);
		logic [4:0] s;
		s = m_head;
		for (int n = 0; s != 0 && n < NSLOT; n++) begin
			if (m_item[s] == key)
				return s;
			s = m_next[s];
		end
		return 5'd0;
	endfunction

	function automatic logic [4:0] list_alloc(logic [31:0] val);
		logic [4:0] c;
		c = m_free;
		m_item[c] = val;
		m_free = m_next[c];
		m_count++;
		return c;
	endfunction

	function automatic list_result_t list_apply(mode_t op, logic [31:0] key,
			logic [31:0] anc, logic [4:0] pos);
		list_result_t r;
		logic [4:0] c, a, s;
		r = '0;
		case (op)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (m_free == 0) begin
					r.status = ST_FULL;
				end else begin
					c = list_alloc(key);
					if (op == MODE_PUSH_FRONT) begin
						m_prev[c] = 0;
						m_next[c] = m_head;
						if (m_head != 0) m_prev[m_head] = c;
						else m_tail = c;
						m_head = c;
					end else begin
						m_next[c] = 0;
						m_prev[c] = m_tail;
						if (m_tail != 0) m_next[m_tail] = c;
						else m_head = c;
						m_tail = c;
					end
					r.slot = c;
				end
			end
			MODE_INS_BEFORE, MODE_INS_AFTER: begin
				if (m_free == 0) begin
					r.status = ST_FULL;
				end else begin
					a = list_find(anc);
					if (a == 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						c = list_alloc(key);
						if (op == MODE_INS_BEFORE) begin
							s = m_prev[a];
							if (s != 0) m_next[s] = c;
							else m_head = c;
							m_prev[c] = s;
							m_next[c] = a;
							m_prev[a] = c;
						end else begin
							s = m_next[a];
							if (s != 0) m_prev[s] = c;
							else m_tail = c;
							m_next[c] = s;
							m_prev[c] = a;
							m_next[a] = c;
						end
						r.slot = c;
					end
				end
			end
			MODE_DELETE: begin
				c = list_find(key);
				if (c == 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					a = m_prev[c];
					s = m_next[c];
					if (a != 0) m_next[a] = s;
					else m_head = s;
					if (s != 0) m_prev[s] = a;
					else m_tail = a;
					if (m_count != 0) m_count--;
					m_next[c] = m_free;
					m_free = c;
					r.slot = c;
					r.item_out = m_item[c];
				end
			end
			MODE_FIND_VALUE: begin
				c = list_find(key);
				if (c == 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot = c;
					r.item_out = m_item[c];
				end
			end
			MODE_FIND_POS: begin
				s = m_head;
				for (int n = 0; n < pos && s != 0; n++)
					s = m_next[s];
				if (s == 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot = s;
					r.item_out = m_item[s];
				end
			end
			default: list_rebuild();
		endcase
		r.count = m_count;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender: one transfer per call, with bursty random gaps
	// ---------------------------------------------------------------
	int burst_left;

	task automatic send_op(mode_t op, logic [31:0] key, logic [31:0] anc = '0,
			logic [4:0] pos = '0);
		list_result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start    <= 1'b1;
		mode     <= op;
		item     <= key;
		anchor   <= anc;
		position <= pos;
		// transfer happens at the first edge with busy low
		do @(posedge clk); while (busy);
		r = list_apply(op, key, anc, pos);
		pending_results.push_back(r);
		n_sent++;
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_NOT_FOUND) n_nf++;
		if (op == MODE_DELETE && r.status == ST_OK) n_del_ok++;
		// keep a list of stored keys for well-formed random traffic
		if (op == MODE_CLEAR)
			live_keys.delete();
		else if (r.status == ST_OK && op <= MODE_INS_AFTER)
			live_keys.push_back(key);
		else if (op == MODE_DELETE && r.status == ST_OK)
			foreach (live_keys[i])
				if (live_keys[i] == key) begin
					live_keys.delete(i);
					break;
				end
	endtask

	// ---------------------------------------------------------------
	// Result monitor: done cannot be held off, so just sample it
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no pending operation: st=%0d slot=%0d",
					$time, status, slot);
				n_errors++;
			end else begin
				e = pending_results.pop_front();
				n_checked++;
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					n_errors++;
				end
				if (slot !== e.slot) begin
					$display("%0t: slot exp %0d got %0d", $time, e.slot, slot);
					n_errors++;
				end
				if (item_out !== e.item_out) begin
					$display("%0t: item_out exp %h got %h", $time, e.item_out, item_out);
					n_errors++;
				end
				if (count !== e.count) begin
					$display("%0t: count exp %0d got %0d", $time, e.count, count);
					n_errors++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_live();
		if (live_keys.size() == 0) return $urandom();
		return live_keys[$urandom_range(0, live_keys.size() - 1)];
	endfunction

	function automatic logic [31:0] small_key();
		// a narrow key range makes duplicates and repeated hits likely
		return ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 40));
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		send_op(MODE_FIND_POS, '0, '0, 5'd0);         // empty list
		send_op(MODE_DELETE, 32'h1);                  // missing target
		send_op(MODE_INS_AFTER, 32'h5, 32'h77);       // missing anchor
		send_op(MODE_PUSH_BACK, 32'hFFFF_FFFF);
		send_op(MODE_DELETE, 32'hFFFF_FFFF);          // sole entry
		send_op(MODE_PUSH_FRONT, 32'h0);
		send_op(MODE_PUSH_BACK, 32'hAAAA_5555);
		send_op(MODE_INS_BEFORE, 32'h5555_AAAA, 32'h0);     // new head
		send_op(MODE_INS_AFTER, 32'h8000_0001, 32'hAAAA_5555); // new tail
		send_op(MODE_INS_AFTER, 32'h1234_5678, 32'h0);
		send_op(MODE_FIND_VALUE, 32'h1234_5678);
		send_op(MODE_FIND_VALUE, 32'hDEAD_BEEF);
		send_op(MODE_FIND_POS, '0, '0, 5'd4);
		send_op(MODE_FIND_POS, '0, '0, 5'd31);
		send_op(MODE_DELETE, 32'h5555_AAAA);          // head
		send_op(MODE_DELETE, 32'h8000_0001);          // tail
		send_op(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
		// fill the table, then hit the full case for a push and an insert
		for (int i = 0; i < NSLOT - 1; i++)
			send_op(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 32'(i * 3 + 1));
		send_op(MODE_PUSH_FRONT, 32'h99);
		send_op(MODE_INS_BEFORE, 32'h99, 32'hFFFF_FFFF); // full before anchor check
		send_op(MODE_FIND_POS, '0, '0, 5'd30);
		send_op(MODE_CLEAR, '0);
	endtask

	task automatic test_random_lists(int n_ops);
		mode_t op;
		int    sel;
		for (int i = 0; i < n_ops; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 18)      op = MODE_PUSH_FRONT;
			else if (sel < 36) op = MODE_PUSH_BACK;
			else if (sel < 48) op = MODE_INS_BEFORE;
			else if (sel < 60) op = MODE_INS_AFTER;
			else if (sel < 76) op = MODE_DELETE;
			else if (sel < 86) op = MODE_FIND_VALUE;
			else if (sel < 98) op = MODE_FIND_POS;
			else               op = MODE_CLEAR;
			case (op)
				MODE_INS_BEFORE, MODE_INS_AFTER:
					send_op(op, small_key(),
						($urandom_range(0, 4) == 0) ? small_key() : pick_live());
				MODE_DELETE, MODE_FIND_VALUE:
					send_op(op, ($urandom_range(0, 4) == 0) ? small_key() : pick_live());
				MODE_FIND_POS:
					send_op(op, $urandom(), $urandom(), 5'($urandom_range(0, 31)));
				default:
					send_op(op, small_key(), $urandom(), 5'($urandom()));
			endcase
		end
	endtask

	task automatic test_wide_random(int n_ops);
		// fully random bits on item, anchor and position; any mode but clear
		for (int i = 0; i < n_ops; i++)
			send_op(mode_t'($urandom_range(0, 6)), $urandom(), $urandom(),
				5'($urandom()));
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		start = 1'b0; mode = '0; item = '0; anchor = '0; position = '0;
		arst_n = 1'b0;
		n_sent = 0; n_checked = 0; n_errors = 0;
		n_full = 0; n_nf = 0; n_del_ok = 0; burst_left = 0;
		for (int i = 0; i < NSLOT; i++) m_item[i] = '0;
		list_rebuild();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_lists(380);
		test_wide_random(60);
		test_random_lists(60);
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("Ran %0d operations, %0d results checked.", n_sent, n_checked);
		$display("Seen: %0d table-full, %0d not-found, %0d deletes.",
			n_full, n_nf, n_del_ok);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
